@@ src/egh_pkg.sv @@
`timescale 1ns / 1ps
package egh_pkg;

  localparam int FracBitsDef = 16;
  localparam int ExpDepthDef = 256;
  localparam int SpanLog2    = 5;
  localparam int DivStages   = 33;
  localparam int FrontLat    = 3;
  localparam int ExpLat      = 4;
  localparam int BackLat     = 4;
  localparam int TotalLat    = FrontLat + DivStages + ExpLat + BackLat;
  localparam int CfgIdxW     = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEIGHT,
    REG_APEX,
    REG_WIDTH,
    REG_TAIL,
    REG_BASE,
    REG_WEIGHT
  } cfg_reg_e;

  typedef logic signed [31:0] word_t;

  typedef struct packed {
    word_t obs;
    word_t ts;
    word_t tsh;
    word_t w;
    logic  dt_neg;
    logic  ok;
  } side_t;

  typedef struct packed {
    word_t v;
    word_t p;
    word_t m;
    word_t aq;
  } aux_t;

  typedef struct packed {
    word_t residual;
    word_t d_height;
    word_t d_apex;
    word_t d_width;
    word_t d_tail;
  } res_t;

  function automatic word_t sat32(input logic signed [64:0] v);
    word_t r;
    if (v > 65'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -65'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Sign-magnitude product, truncated toward zero after the shift.
  function automatic logic signed [64:0] mulsh(input word_t a, input word_t b, input int sh);
    logic [31:0]        ma;
    logic [31:0]        mb;
    logic [63:0]        p;
    logic signed [64:0] r;
    ma = a[31] ? 32'(-a) : 32'(a);
    mb = b[31] ? 32'(-b) : 32'(b);
    p  = (64'(ma) * 64'(mb)) >> sh;
    r  = $signed({1'b0, p});
    if (a[31] ^ b[31]) begin
      r = -r;
    end
    return r;
  endfunction

  // Entry k of the exp(-x) table in Q.30; step is the grid spacing in Q.30.
  function automatic logic [30:0] exp_entry(input int k, input logic [63:0] step);
    logic [63:0]        term;
    logic [63:0]        ratio;
    logic [63:0]        e;
    logic signed [63:0] sum;
    term = 64'd1 << 30;
    sum  = $signed(64'd1 << 30);
    for (int n = 1; n <= 40; n++) begin
      if (term != 64'd0) begin
        term = ((term * step) >> 30) / 64'(n);
        if (n[0]) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
    end
    ratio = sum[63] ? 64'd0 : 64'(sum);
    if (ratio > (64'd1 << 30)) begin
      ratio = 64'd1 << 30;
    end
    e = 64'd1 << 30;
    for (int j = 0; j < k; j++) begin
      e = (e * ratio + (64'd1 << 29)) >> 30;
    end
    return e[30:0];
  endfunction

endpackage

@@ src/egh_if.sv @@
`timescale 1ns / 1ps
interface egh_in_if import egh_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t sample_time;
  word_t observed_level;
  word_t trace_scale;

  modport source (output valid, sample_time, observed_level, trace_scale, input ready);
  modport sink (input valid, sample_time, observed_level, trace_scale, output ready);
endinterface

interface egh_out_if import egh_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t residual;
  word_t d_height;
  word_t d_apex;
  word_t d_width;
  word_t d_tail;

  modport source (output valid, residual, d_height, d_apex, d_width, d_tail, input ready);
  modport sink (input valid, residual, d_height, d_apex, d_width, d_tail, output ready);
endinterface

@@ src/egh_front.sv @@
`timescale 1ns / 1ps
module egh_front import egh_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  word_t                       sample_time_i,
  input  word_t                       observed_level_i,
  input  word_t                       trace_scale_i,
  input  word_t                       peak_height_i,
  input  word_t                       apex_time_i,
  input  word_t                       gauss_width_i,
  input  word_t                       tail_factor_i,
  input  logic                        weight_enable_i,
  output logic [63+FRAC_BITS-1:0]     num_a_o,
  output logic [32+2*FRAC_BITS-1:0]   num_v_o,
  output logic [63+FRAC_BITS-1:0]     num_p_o,
  output logic [32+2*FRAC_BITS-1:0]   num_m_o,
  output logic [63:0]                 den_o,
  output side_t                       side_o
);

  // Stage 1: distance from the apex, magnitudes and the weight.
  word_t       dt_sat;
  logic [31:0] adt_d;
  logic [31:0] sig_d;
  word_t       w_d;

  word_t       dt1_q;
  logic [31:0] adt1_q;
  logic [31:0] sig1_q;
  word_t       obs1_q;
  word_t       ts1_q;
  word_t       w1_q;

  always_comb begin
    dt_sat = sat32(65'(sample_time_i) - 65'(apex_time_i));
    adt_d  = dt_sat[31] ? 32'(-dt_sat) : 32'(dt_sat);
    sig_d  = gauss_width_i[31] ? 32'(-gauss_width_i) : 32'(gauss_width_i);
    w_d    = weight_enable_i ? trace_scale_i : (32'sd1 <<< FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dt1_q  <= dt_sat;
      adt1_q <= adt_d;
      sig1_q <= sig_d;
      obs1_q <= observed_level_i;
      ts1_q  <= trace_scale_i;
      w1_q   <= w_d;
    end
  end

  // Stage 2: the squares, the tail product and trace_scale * height.
  logic [63:0]        dt2_q;
  logic [63:0]        s2_q;
  logic signed [63:0] tdt_q;
  word_t              tsh2_q;
  logic [31:0]        adt2_q;
  logic [31:0]        sig2_q;
  logic               neg2_q;
  word_t              obs2_q;
  word_t              ts2_q;
  word_t              w2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dt2_q  <= 64'(adt1_q) * 64'(adt1_q);
      s2_q   <= 64'(sig1_q) * 64'(sig1_q);
      tdt_q  <= 64'(tail_factor_i) * 64'(dt1_q);
      tsh2_q <= sat32(mulsh(ts1_q, peak_height_i, FRAC_BITS));
      adt2_q <= adt1_q;
      sig2_q <= sig1_q;
      neg2_q <= dt1_q[31];
      obs2_q <= obs1_q;
      ts2_q  <= ts1_q;
      w2_q   <= w1_q;
    end
  end

  // Stage 3: denominator 2*sigma^2 + tau*dt and its sign test.
  logic [63:0] twos2;
  logic [63:0] magt;
  logic [63:0] den_d;
  logic        ok_d;

  always_comb begin
    twos2 = {s2_q[62:0], 1'b0};
    magt  = 64'(-tdt_q);
    if (!tdt_q[63]) begin
      den_d = twos2 + 64'(tdt_q);
      ok_d  = den_d != 64'd0;
    end else begin
      den_d = twos2 - magt;
      ok_d  = magt < twos2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_a_o     <= {dt2_q[62:0], {FRAC_BITS{1'b0}}};
      num_v_o     <= {adt2_q, {(2*FRAC_BITS){1'b0}}};
      num_p_o     <= {s2_q[62:0], {FRAC_BITS{1'b0}}};
      num_m_o     <= {sig2_q, {(2*FRAC_BITS){1'b0}}};
      den_o       <= den_d;
      side_o.obs  <= obs2_q;
      side_o.ts   <= ts2_q;
      side_o.tsh  <= tsh2_q;
      side_o.w    <= w2_q;
      side_o.dt_neg <= neg2_q;
      side_o.ok   <= ok_d;
    end
  end

endmodule

@@ src/egh_div.sv @@
`timescale 1ns / 1ps
module egh_div import egh_pkg::*; #(
  parameter int NUMW = 64
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NUMW-1:0] num_i,
  input  logic [63:0]     den_i,
  output logic [31:0]     quo_o
);

  localparam int CW = (NUMW > 96) ? NUMW : 96;

  logic [CW-1:0] rem_q [DivStages-1];
  logic [63:0]   den_q [DivStages-1];
  logic [31:0]   quo_q [DivStages];
  logic          ovf_q [DivStages];

  // First stage flags a quotient of 2^32 or more, which saturates anyway.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= CW'(num_i);
      den_q[0] <= den_i;
      ovf_q[0] <= CW'(num_i) >= (CW'(den_i) << 32);
      quo_q[0] <= '0;
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar s = 1; s < DivStages; s++) begin : g_stage
    localparam int Bit = DivStages - 1 - s;
    logic [CW-1:0] sub;
    logic          take;

    assign sub  = CW'(den_q[s-1]) << Bit;
    assign take = rem_q[s-1] >= sub;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[s] <= quo_q[s-1] | (take ? (32'd1 << Bit) : 32'd0);
        ovf_q[s] <= ovf_q[s-1];
      end
    end

    if (s < DivStages - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= take ? (rem_q[s-1] - sub) : rem_q[s-1];
          den_q[s] <= den_q[s-1];
        end
      end
    end
  end

  assign quo_o = (ovf_q[DivStages-1] || (quo_q[DivStages-1] > 32'h8000_0000)) ?
                 32'h8000_0000 : quo_q[DivStages-1];

endmodule

@@ src/egh_exp.sv @@
`timescale 1ns / 1ps
module egh_exp import egh_pkg::*; #(
  parameter int FRAC_BITS       = FracBitsDef,
  parameter int EXP_TABLE_DEPTH = ExpDepthDef
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  output logic [30:0] e_o
);

  localparam int SH   = FRAC_BITS + SpanLog2;
  localparam int IW   = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int POSW = SH + IW;
  localparam logic [63:0] Step = (64'd1 << (30 + SpanLog2)) / EXP_TABLE_DEPTH;

  logic [30:0] exp_tab [EXP_TABLE_DEPTH+1];

  for (genvar k = 0; k <= EXP_TABLE_DEPTH; k++) begin : g_tab
    localparam logic [30:0] Val = exp_entry(k, Step);
    assign exp_tab[k] = Val;
  end

  // Stage 1: range check and position on the table grid.
  logic            far1_q;
  logic [POSW-1:0] pos1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      far1_q <= (a_i >> SH) != 32'd0;
      pos1_q <= POSW'(a_i[SH-1:0]) * POSW'(EXP_TABLE_DEPTH);
    end
  end

  // Stage 2: table lookup of the two neighbors.
  logic [IW-1:0] idx;
  logic [IW-1:0] idx_nx;

  assign idx    = pos1_q[POSW-1:SH];
  assign idx_nx = idx + IW'(1);

  logic          far2_q;
  logic [30:0]   t02_q;
  logic [30:0]   diff2_q;
  logic [SH-1:0] rem2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      far2_q  <= far1_q;
      t02_q   <= exp_tab[idx];
      diff2_q <= exp_tab[idx] - exp_tab[idx_nx];
      rem2_q  <= pos1_q[SH-1:0];
    end
  end

  // Stage 3: interpolation product.
  logic             far3_q;
  logic [30:0]      t03_q;
  logic [31+SH-1:0] prod3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      far3_q  <= far2_q;
      t03_q   <= t02_q;
      prod3_q <= (31+SH)'(diff2_q) * (31+SH)'(rem2_q);
    end
  end

  // Stage 4: interpolated value, zero beyond the table span.
  logic [30:0] e4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e4_q <= far3_q ? 31'd0 : (t03_q - 31'(prod3_q >> SH));
    end
  end

  assign e_o = e4_q;

endmodule

@@ src/egh_back.sv @@
`timescale 1ns / 1ps
module egh_back import egh_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] e_i,
  input  side_t       side_i,
  input  aux_t        aux_i,
  input  word_t       base_level_i,
  output res_t        res_o
);

  word_t e_w;
  assign e_w = word_t'({1'b0, e_i});

  // Stage 1: amplitude and the inner factors.
  word_t amp1_q, th1_q, pv1_q, am1_q, ft1_q, v1_q, obs1_q, w1_q;
  logic  ok1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      amp1_q <= sat32(mulsh(side_i.tsh, e_w, 30));
      th1_q  <= sat32(mulsh(side_i.ts, e_w, 30));
      pv1_q  <= sat32(mulsh(aux_i.p, aux_i.v, FRAC_BITS));
      am1_q  <= sat32(mulsh(aux_i.aq, aux_i.m, FRAC_BITS));
      ft1_q  <= sat32(mulsh(aux_i.aq, aux_i.v, FRAC_BITS));
      v1_q   <= aux_i.v;
      obs1_q <= side_i.obs;
      w1_q   <= side_i.w;
      ok1_q  <= side_i.ok;
    end
  end

  // Stage 2: model value and the apex and width factors.
  word_t model2_q, fr2_q, fs2_q, dh2_q, amp2_q, ft2_q, obs2_q, w2_q;
  logic  ok2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      model2_q <= ok1_q ? sat32(65'(base_level_i) + 65'(amp1_q)) : '0;
      fr2_q    <= sat32(65'(v1_q) + (65'(pv1_q) <<< 1));
      fs2_q    <= sat32(65'(am1_q) <<< 2);
      dh2_q    <= sat32(mulsh(th1_q, w1_q, FRAC_BITS));
      amp2_q   <= amp1_q;
      ft2_q    <= ft1_q;
      obs2_q   <= obs1_q;
      w2_q     <= w1_q;
      ok2_q    <= ok1_q;
    end
  end

  // Stage 3: unweighted derivatives and the raw residual.
  word_t diff3_q, ra3_q, sa3_q, ta3_q, dh3_q, w3_q;
  logic  ok3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff3_q <= sat32(65'(model2_q) - 65'(obs2_q));
      ra3_q   <= sat32(mulsh(amp2_q, fr2_q, FRAC_BITS));
      sa3_q   <= sat32(mulsh(amp2_q, fs2_q, FRAC_BITS));
      ta3_q   <= sat32(mulsh(amp2_q, ft2_q, FRAC_BITS));
      dh3_q   <= dh2_q;
      w3_q    <= w2_q;
      ok3_q   <= ok2_q;
    end
  end

  // Stage 4: weighting; this is the output register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o.residual <= sat32(mulsh(diff3_q, w3_q, FRAC_BITS));
      res_o.d_height <= ok3_q ? dh3_q : '0;
      res_o.d_apex   <= ok3_q ? sat32(mulsh(ra3_q, w3_q, FRAC_BITS)) : '0;
      res_o.d_width  <= ok3_q ? sat32(mulsh(sa3_q, w3_q, FRAC_BITS)) : '0;
      res_o.d_tail   <= ok3_q ? sat32(mulsh(ta3_q, w3_q, FRAC_BITS)) : '0;
    end
  end

endmodule

@@ src/egh_residual_jacobian.sv @@
`timescale 1ns / 1ps
// An accepted sample word passes the front end, the divider lanes, the exp unit and the back end to its result word.
// Throughput: one word per cycle; the whole pipeline advances together and holds
// when a finished result is not taken.
// The depth is set by the 33-stage restoring divider lanes (one quotient bit per stage after the first).
// Reset clears the valid bits and loads the configuration registers with their defaults.
module egh_residual_jacobian import egh_pkg::*; #(
  parameter int FRAC_BITS       = FracBitsDef,
  parameter int EXP_TABLE_DEPTH = ExpDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  egh_in_if.sink             samp_i,
  egh_out_if.source          res_o
);

  localparam int NumAW = 63 + FRAC_BITS;
  localparam int NumVW = 32 + 2 * FRAC_BITS;
  localparam int SideLen = DivStages + ExpLat;

  word_t height_q, apex_q, width_q, tail_q, base_q;
  logic  wen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= '0;
      apex_q   <= '0;
      width_q  <= 32'sd1 <<< FRAC_BITS;
      tail_q   <= '0;
      base_q   <= '0;
      wen_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_APEX:   apex_q   <= cfg_data_i;
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_TAIL:   tail_q   <= cfg_data_i;
        REG_BASE:   base_q   <= cfg_data_i;
        REG_WEIGHT: wen_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic                en;
  logic [TotalLat-1:0] vld_q;

  assign en           = !vld_q[TotalLat-1] || res_o.ready;
  assign samp_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TotalLat-2:0], samp_i.valid};
    end
  end

  logic [NumAW-1:0] num_a, num_p;
  logic [NumVW-1:0] num_v, num_m;
  logic [63:0]      den;
  side_t            front_side;

  egh_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i           (clk_i),
    .en_i            (en),
    .sample_time_i   (samp_i.sample_time),
    .observed_level_i(samp_i.observed_level),
    .trace_scale_i   (samp_i.trace_scale),
    .peak_height_i   (height_q),
    .apex_time_i     (apex_q),
    .gauss_width_i   (width_q),
    .tail_factor_i   (tail_q),
    .weight_enable_i (wen_q),
    .num_a_o         (num_a),
    .num_v_o         (num_v),
    .num_p_o         (num_p),
    .num_m_o         (num_m),
    .den_o           (den),
    .side_o          (front_side)
  );

  logic [31:0] qa, qv, qp, qm;

  egh_div #(.NUMW(NumAW)) u_div_a (.clk_i(clk_i), .en_i(en), .num_i(num_a), .den_i(den), .quo_o(qa));
  egh_div #(.NUMW(NumVW)) u_div_v (.clk_i(clk_i), .en_i(en), .num_i(num_v), .den_i(den), .quo_o(qv));
  egh_div #(.NUMW(NumAW)) u_div_p (.clk_i(clk_i), .en_i(en), .num_i(num_p), .den_i(den), .quo_o(qp));
  egh_div #(.NUMW(NumVW)) u_div_m (.clk_i(clk_i), .en_i(en), .num_i(num_m), .den_i(den), .quo_o(qm));

  // Side data rides along the divider lanes and the exp unit.
  side_t side_q [SideLen];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= front_side;
      for (int k = 1; k < SideLen; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Quotients saturate at 2^31 - 1; the velocity term takes the sign of dt.
  aux_t  aux_d;
  word_t vmag;

  always_comb begin
    vmag     = qv[31] ? 32'sh7FFF_FFFF : word_t'(qv);
    aux_d.v  = side_q[DivStages-1].dt_neg ? -vmag : vmag;
    aux_d.p  = qp[31] ? 32'sh7FFF_FFFF : word_t'(qp);
    aux_d.m  = qm[31] ? 32'sh7FFF_FFFF : word_t'(qm);
    aux_d.aq = qa[31] ? 32'sh7FFF_FFFF : word_t'(qa);
  end

  aux_t aux_q [ExpLat];

  always_ff @(posedge clk_i) begin
    if (en) begin
      aux_q[0] <= aux_d;
      for (int k = 1; k < ExpLat; k++) begin
        aux_q[k] <= aux_q[k-1];
      end
    end
  end

  logic [30:0] e_val;

  egh_exp #(.FRAC_BITS(FRAC_BITS), .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_exp (
    .clk_i(clk_i),
    .en_i (en),
    .a_i  (qa),
    .e_o  (e_val)
  );

  res_t res;

  egh_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .en_i        (en),
    .e_i         (e_val),
    .side_i      (side_q[SideLen-1]),
    .aux_i       (aux_q[ExpLat-1]),
    .base_level_i(base_q),
    .res_o       (res)
  );

  assign res_o.valid    = vld_q[TotalLat-1];
  assign res_o.residual = res.residual;
  assign res_o.d_height = res.d_height;
  assign res_o.d_apex   = res.d_apex;
  assign res_o.d_width  = res.d_width;
  assign res_o.d_tail   = res.d_tail;

endmodule

@@ src/egh_checker.sv @@
`timescale 1ns / 1ps
module egh_checker import egh_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_ready_i,
  input logic  out_valid_i,
  input logic  out_ready_i,
  input word_t residual_i
);

  localparam int CntW = $clog2(TotalLat + 1);

  logic            in_fire, out_fire;
  logic [CntW-1:0] cnt_q;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // Words accepted and not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_fire && !out_fire) begin
      cnt_q <= cnt_q + CntW'(1);
    end else if (out_fire && !in_fire) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(residual_i))
    else $error("result word changed while stalled");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input held off while the output is free");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> cnt_q != '0)
    else $error("result word without an accepted sample");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !out_fire |-> cnt_q < CntW'(TotalLat))
    else $error("more words in flight than pipeline stages");

endmodule

bind egh_residual_jacobian egh_checker u_egh_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (samp_i.valid),
  .in_ready_i (samp_i.ready),
  .out_valid_i(res_o.valid),
  .out_ready_i(res_o.ready),
  .residual_i (res_o.residual)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import egh_pkg::*;

  localparam int Frac = 16;
  localparam int Depth = 256;
  localparam int Lat = TotalLat;
  localparam longint CycleLimit = 400000;

  typedef struct packed {
    word_t t;
    word_t obs;
    word_t ts;
  } samp_t;

  // One row of the directed table; chk says whether exp holds a typed-in result.
  typedef struct {
    samp_t s;
    bit    chk;
    res_t  exp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  egh_in_if samp_if ();
  egh_out_if res_if ();

  egh_residual_jacobian u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .samp_i    (samp_if.sink),
    .res_o     (res_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Configuration mirror used by the predictor.
  logic signed [31:0] m_height = 0, m_apex = 0, m_width = 65536, m_tail = 0, m_base = 0;
  logic m_weight = 1'b0;
  logic [63:0] exp_lut [0:Depth];

  res_t   pending_q [$];
  int     err_cnt = 0;
  longint cyc = 0;
  bit     hold_rx = 1'b0;
  bit     done_tx = 1'b0;

  function automatic longint s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint smul(longint a, longint b, int sh);
    logic [63:0] ma, mb, p;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p = (ma * mb) >> sh;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  // Quotient num*2^sh/den, floored, capped at 2^31.
  function automatic logic [63:0] qdiv(logic [63:0] num, logic [63:0] den, int sh);
    logic [63:0] q, r;
    q = num / den;
    r = num % den;
    if (q > 64'h8000_0000) return 64'h8000_0000;
    for (int i = 0; i < sh; i++) begin
      q = q << 1;
      if (r >= den - r) begin
        r = r - (den - r);
        q++;
      end else begin
        r = r << 1;
      end
      if (q > 64'h8000_0000) return 64'h8000_0000;
    end
    return q;
  endfunction

  task automatic build_lut();
    logic [63:0] step, term, ratio;
    longint sum;
    step = (64'd1 << 35) / Depth;
    term = 64'd1 << 30;
    sum = longint'(64'd1 << 30);
    for (int n = 1; n <= 40 && term != 0; n++) begin
      term = ((term * step) >> 30) / n;
      sum = (n % 2) ? sum - longint'(term) : sum + longint'(term);
    end
    ratio = sum < 0 ? 64'd0 : 64'(sum);
    if (ratio > (64'd1 << 30)) ratio = 64'd1 << 30;
    exp_lut[0] = 64'd1 << 30;
    for (int k = 1; k <= Depth; k++) exp_lut[k] = (exp_lut[k-1] * ratio + (64'd1 << 29)) >> 30;
  endtask

  function automatic logic [63:0] exp_neg(logic [63:0] a);
    logic [63:0] pos, idx, rem;
    if (a >= (64'd1 << 21)) return 0;
    pos = a * Depth;
    idx = pos >> 21;
    rem = pos & ((64'd1 << 21) - 1);
    return exp_lut[idx] - (((exp_lut[idx] - exp_lut[idx+1]) * rem) >> 21);
  endfunction

  function automatic res_t peak_jacobian(samp_t s);
    res_t r;
    longint t, obs, ts, w, dt, tdt, model, dh, dr, ds, dtl, v, p, m, as, amp;
    logic [63:0] sig, adt, dt2, s2, two, den, a, e;
    bit ok;
    t = s.t; obs = s.obs; ts = s.ts;
    sig = m_width < 0 ? -longint'(m_width) : longint'(m_width);
    w = m_weight ? ts : (64'sd1 << Frac);
    model = 0; dh = 0; dr = 0; ds = 0; dtl = 0;
    dt = s32(t - longint'(m_apex));
    adt = dt < 0 ? -dt : dt;
    dt2 = adt * adt;
    s2 = sig * sig;
    two = s2 << 1;
    tdt = longint'(m_tail) * dt;
    if (tdt >= 0) begin
      den = two + 64'(tdt);
      ok = den > 0;
    end else if (64'(-tdt) >= two) begin
      den = 0;
      ok = 0;
    end else begin
      den = two - 64'(-tdt);
      ok = 1;
    end
    if (ok) begin
      a = qdiv(dt2, den, Frac);
      e = exp_neg(a);
      v = s32(longint'(qdiv(adt, den, 2 * Frac)));
      p = s32(longint'(qdiv(s2, den, Frac)));
      m = s32(longint'(qdiv(sig, den, 2 * Frac)));
      as = s32(longint'(a));
      if (dt < 0) v = -v;
      amp = s32(smul(s32(smul(ts, m_height, Frac)), longint'(e), 30));
      model = s32(longint'(m_base) + amp);
      dh = s32(smul(s32(smul(ts, longint'(e), 30)), w, Frac));
      dr = s32(smul(s32(smul(amp, s32(v + 2 * s32(smul(p, v, Frac))), Frac)), w, Frac));
      ds = s32(smul(s32(smul(amp, s32(4 * s32(smul(as, m, Frac))), Frac)), w, Frac));
      dtl = s32(smul(s32(smul(amp, s32(smul(as, v, Frac)), Frac)), w, Frac));
    end
    r.residual = 32'(s32(smul(s32(model - obs), w, Frac)));
    r.d_height = 32'(dh);
    r.d_apex = 32'(dr);
    r.d_width = 32'(ds);
    r.d_tail = 32'(dtl);
    return r;
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_HEIGHT: m_height = val;
      REG_APEX:   m_apex = val;
      REG_WIDTH:  m_width = val;
      REG_TAIL:   m_tail = val;
      REG_BASE:   m_base = val;
      REG_WEIGHT: m_weight = val[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    samp_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (Lat + 4) @(posedge clk_i);
  endtask

  // Valid stays high after an accepted word; it drops only when the sender idles.
  task automatic send(samp_t s, bit chk, res_t exp_r, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 16) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      samp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    samp_if.valid <= 1'b1;
    samp_if.sample_time <= s.t;
    samp_if.observed_level <= s.obs;
    samp_if.trace_scale <= s.ts;
    pending_q.push_back(chk ? exp_r : peak_jacobian(s));
    @(posedge clk_i);
    while (!samp_if.ready) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 8) << 16;
      3: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      default: return $urandom;
    endcase
  endfunction

  // Mostly samples near the apex so the exp table and derivatives are exercised.
  function automatic samp_t rnd_samp();
    samp_t s;
    if ($urandom_range(0, 3) != 0) begin
      s.t = m_apex + 32'($signed($urandom_range(0, 12 << 16)) - (6 << 16));
      s.obs = 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
      s.ts = $urandom_range(0, 4 << 16);
    end else begin
      s.t = rnd_word();
      s.obs = rnd_word();
      s.ts = rnd_word();
    end
    return s;
  endfunction

  initial begin
    row_t tbl [$];
    row_t rw;
    res_t zr;
    samp_t s;
    samp_if.valid = 1'b0;
    samp_if.sample_time = '0;
    samp_if.observed_level = '0;
    samp_if.trace_scale = '0;
    build_lut();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset the height is zero: only the residual and d_height can be nonzero.
    zr = '0;
    rw.chk = 1'b1; rw.exp = zr;
    rw.s = '{32'sd0, 32'sd0, 32'sd0}; tbl.push_back(rw);
    rw.s = '{32'sd0, 32'sh8000_0000, 32'sd0}; rw.exp.residual = 32'sh7FFF_FFFF;
    tbl.push_back(rw);
    rw.s = '{32'sd0, 32'sh7FFF_FFFF, 32'sd0}; rw.exp.residual = 32'sh8000_0001;
    tbl.push_back(rw);
    rw.chk = 1'b0;
    rw.s = '{32'sh7FFF_FFFF, 32'sh10000, 32'sh7FFF_FFFF}; tbl.push_back(rw);
    rw.s = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}; tbl.push_back(rw);
    rw.s = '{32'sd0, 32'sd0, 32'sh10000}; tbl.push_back(rw);
    rw.s = '{32'sh8000, 32'sh1234, 32'sh20000}; tbl.push_back(rw);
    foreach (tbl[i]) send(tbl[i].s, tbl[i].chk, tbl[i].exp, 1'b1);
    drain();

    // Peak with tail, negative sigma, weighting on.
    write_reg(REG_HEIGHT, 32'h0005_0000);
    write_reg(REG_APEX, 32'h0003_0000);
    write_reg(REG_WIDTH, 32'hFFFF_0000);
    write_reg(REG_TAIL, 32'h0000_8000);
    write_reg(REG_BASE, 32'h0000_4000);
    write_reg(REG_WEIGHT, 32'h1);
    tbl.delete();
    rw.chk = 1'b0;
    rw.s = '{32'h0003_0000, 32'h0, 32'h0001_0000}; tbl.push_back(rw);
    rw.s = '{32'h0004_0000, 32'h0, 32'h0002_0000}; tbl.push_back(rw);
    rw.s = '{32'h0002_0000, 32'h1_0000, 32'hFFFF_0000}; tbl.push_back(rw);
    rw.s = '{32'hFFF0_0000, 32'h0, 32'h0001_0000}; tbl.push_back(rw);  // denominator <= 0
    rw.s = '{32'h0040_0000, 32'h0, 32'h0001_0000}; tbl.push_back(rw);  // far tail
    rw.s = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF}; tbl.push_back(rw);
    foreach (tbl[i]) send(tbl[i].s, tbl[i].chk, tbl[i].exp, 1'b1);
    drain();

    // Zero sigma and tau: the denominator vanishes, the baseline is dropped.
    write_reg(REG_WIDTH, 32'h0);
    write_reg(REG_TAIL, 32'h0);
    rw.chk = 1'b1; rw.exp = '0; rw.exp.residual = 32'shFFFE_0000;
    send('{32'h1_0000, 32'h1_0000, 32'h2_0000}, 1'b1, rw.exp, 1'b0);
    rw.exp.residual = 32'sh8000_0000;
    send('{32'h1_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b1, rw.exp, 1'b0);
    drain();

    // Random phases, each with a fresh setting including extremes.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_HEIGHT, ph == 1 ? 32'h7FFF_FFFF : ph == 2 ? 32'h8000_0000 :
                32'($signed($urandom_range(0, 20 << 16)) - (10 << 16)));
      write_reg(REG_APEX, ph == 3 ? 32'h8000_0000 : ph == 4 ? 32'h7FFF_FFFF : rnd_word());
      write_reg(REG_WIDTH, ph == 5 ? 32'h7FFF_FFFF : ph == 6 ? 32'h8000_0000 :
                32'($signed($urandom_range(1, 6 << 16)) * ($urandom_range(0, 1) ? 1 : -1)));
      write_reg(REG_TAIL, ph == 7 ? 32'h8000_0000 : ph == 2 ? 32'h7FFF_FFFF :
                32'($signed($urandom_range(0, 4 << 16)) - (2 << 16)));
      write_reg(REG_BASE, ph == 1 ? 32'h7FFF_FFFF : ph == 5 ? 32'h8000_0000 : rnd_word());
      write_reg(REG_WEIGHT, ph % 2);
      for (int i = 0; i < 160; i++) begin
        s = rnd_samp();
        rw.chk = 1'b0;
        send(s, 1'b0, zr, !(ph == 3 && i < 80));
        if (ph == 2 && i == 10) hold_rx = 1'b1;
        // Pause the sender until everything has drained.
        if (ph == 4 && i == 50) begin
          samp_if.valid <= 1'b0;
          while (pending_q.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end
    done_tx = 1'b1;
  end

  // Receiver with random stalls and one long hold-off.
  initial begin
    int gap;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_rx) begin
        res_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap == 0) begin
        res_if.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        res_if.ready <= 1'b1;
        @(posedge clk_i);
      end
      while (!(res_if.valid && res_if.ready)) @(posedge clk_i);
    end
  end

  // Result check at every accepted word.
  always @(posedge clk_i) begin
    res_t want, got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = '{res_if.residual, res_if.d_height, res_if.d_apex, res_if.d_width,
              res_if.d_tail};
      if (pending_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result word %h", got);
      end else begin
        want = pending_q.pop_front();
        if (want !== got) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: res %h/%h dh %h/%h da %h/%h dw %h/%h dt %h/%h",
                     want.residual, got.residual, want.d_height, got.d_height,
                     want.d_apex, got.d_apex, want.d_width, got.d_width,
                     want.d_tail, got.d_tail);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (done_tx) begin
      if (err_cnt == 0 && pending_q.size() == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
    end else if (cyc > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

@@ sim.f @@
src/egh_pkg.sv
src/egh_if.sv
src/egh_front.sv
src/egh_div.sv
src/egh_exp.sv
src/egh_back.sv
src/egh_residual_jacobian.sv
src/egh_checker.sv
tb/testbench.sv
